/* src/hss_pkg.sv */
// ----------------------------------------------------------------------------
// Hot-spot smoother package
// Shared types and constants for the hot-spot smoother block.
// ----------------------------------------------------------------------------
`default_nettype none

package hss_pkg;

  localparam int WINDOW_LEN_DEF = 8;
  localparam int COORD_W        = 8;
  localparam int TEMP_W         = 15;

  typedef struct packed {
    logic [7:0]               blue;
    logic [7:0]               green;
    logic [7:0]               red;
    logic signed [TEMP_W-1:0] temp;
    logic [COORD_W-1:0]       y;
    logic [COORD_W-1:0]       x;
  } sample_t;

  localparam int SAMPLE_W = $bits(sample_t);
  localparam int TDATA_W  = 56;

  localparam logic [1:0] REG_HOLD  = 2'd0;
  localparam logic [1:0] REG_CLEAR = 2'd1;
  localparam logic [1:0] REG_JUMP  = 2'd2;

  localparam logic [3:0] HOLD_RST  = 4'd3;
  localparam logic [7:0] CLEAR_RST = 8'd10;
  localparam logic [8:0] JUMP_RST  = 9'd20;

  localparam logic [7:0] MISS_MAX = 8'd255;

  localparam logic signed [TEMP_W-1:0] COLD_TEMP = -15'sd16000;

endpackage

`default_nettype wire

/* src/hot_spot_smoother_top.sv */
// ----------------------------------------------------------------------------
// Hot-spot smoother
// Keeps a window of recent hot-spot detections and reports the smoothed spot.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. A missed frame either passes through
// or replays the window, and a found frame is appended to the window
// before it is replayed. The time a replay takes is set by the walk over
// the window through the single read port of the sample memory and by the
// eight-step divider that forms the mean position. A finished result waits
// in the output register while the next transaction is taken; a result
// that is still waiting when the next one is finished holds the block
// until it is taken.
`default_nettype none

module hot_spot_smoother_top
  import hss_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output logic                    s_tready,
  // x[7:0], y[15:8], temp[30:16], red[38:31], green[46:39], blue[54:47]
  input  wire logic [TDATA_W-1:0] s_tdata,
  // spot_found[0]
  input  wire logic               s_tuser,
  output logic                    m_tvalid,
  input  wire logic               m_tready,
  // x[7:0], y[15:8], temp[30:16], red[38:31], green[46:39], blue[54:47]
  output logic      [TDATA_W-1:0] m_tdata,
  // out_found[0]
  output logic                    m_tuser,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [8:0]         cfg_data
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W  = COORD_W + CNT_W;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_RD_LAST = 3'd1;
  localparam logic [2:0] ST_SQUARE  = 3'd2;
  localparam logic [2:0] ST_JUMP    = 3'd3;
  localparam logic [2:0] ST_APPEND  = 3'd4;
  localparam logic [2:0] ST_SCAN    = 3'd5;
  localparam logic [2:0] ST_DIVIDE  = 3'd6;
  localparam logic [2:0] ST_OUTPUT  = 3'd7;

  function automatic logic [SLOT_W-1:0] slot_at(input logic [SLOT_W-1:0] base,
                                                input logic [CNT_W-1:0]  k);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(k);
    if (sum >= (CNT_W+1)'(WINDOW_LEN)) begin
      sum = sum - (CNT_W+1)'(WINDOW_LEN);
    end
    return SLOT_W'(sum);
  endfunction

  logic [2:0]               state;
  logic [3:0]               reg_hold;
  logic [7:0]               reg_clear;
  logic [8:0]               reg_jump;
  logic [17:0]              jump_sq;

  sample_t                  cur;
  logic                     pass;
  logic [CNT_W-1:0]         count;
  logic [SLOT_W-1:0]        oldest;
  logic [7:0]               missed;

  logic [CNT_W-1:0]         scan_k;
  logic                     rd_pend;
  logic                     rd_last;
  logic [SUM_W-1:0]         sum_x;
  logic [SUM_W-1:0]         sum_y;
  logic signed [TEMP_W-1:0] best;
  logic [7:0]               pick_red;
  logic [7:0]               pick_green;
  logic [7:0]               pick_blue;
  logic [15:0]              dx_sq;
  logic [15:0]              dy_sq;

  logic                     div_start;
  logic                     div_done;
  logic [COORD_W-1:0]       mean_x;
  logic [COORD_W-1:0]       mean_y;

  logic                     wr_en;
  logic [SLOT_W-1:0]        wr_addr;
  logic                     rd_en;
  logic [SLOT_W-1:0]        rd_addr;
  sample_t                  rd_data;

  logic                     window_full;
  logic [7:0]               missed_inc;
  logic                     replay;
  logic [COORD_W-1:0]       dx;
  logic [COORD_W-1:0]       dy;
  sample_t                  result;

  assign s_tready    = (state == ST_IDLE);
  assign cfg_ready   = 1'b1;
  assign window_full = (count == CNT_W'(WINDOW_LEN));
  assign missed_inc  = (missed == MISS_MAX) ? missed : missed + 8'd1;
  assign replay      = (missed_inc <= {4'd0, reg_hold}) && (count != '0);
  assign dx          = (cur.x > rd_data.x) ? cur.x - rd_data.x : rd_data.x - cur.x;
  assign dy          = (cur.y > rd_data.y) ? cur.y - rd_data.y : rd_data.y - cur.y;

  always_comb begin
    result.x     = mean_x;
    result.y     = mean_y;
    result.temp  = best;
    result.red   = pick_red;
    result.green = pick_green;
    result.blue  = pick_blue;
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = slot_at(oldest, count - CNT_W'(1));
    wr_en   = 1'b0;
    wr_addr = window_full ? oldest : slot_at(oldest, count);
    case (state)
      ST_RD_LAST: begin
        rd_en = 1'b1;
      end
      ST_SCAN: begin
        if (scan_k < count) begin
          rd_en   = 1'b1;
          rd_addr = slot_at(oldest, scan_k);
        end
      end
      ST_APPEND: begin
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  hss_window_mem #(
    .DEPTH  (WINDOW_LEN),
    .ADDR_W (SLOT_W),
    .DATA_W (SAMPLE_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (cur),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  hss_mean_div #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .sum_x  (sum_x),
    .sum_y  (sum_y),
    .count  (count),
    .done   (div_done),
    .mean_x (mean_x),
    .mean_y (mean_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      reg_hold  <= HOLD_RST;
      reg_clear <= CLEAR_RST;
      reg_jump  <= JUMP_RST;
      jump_sq   <= 18'(JUMP_RST) * 18'(JUMP_RST);
      count     <= '0;
      oldest    <= '0;
      missed    <= '0;
      m_tvalid  <= 1'b0;
      div_start <= 1'b0;
      rd_pend   <= 1'b0;
      rd_last   <= 1'b0;
      scan_k    <= '0;
    end else begin
      jump_sq <= 18'(reg_jump) * 18'(reg_jump);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_HOLD:  reg_hold  <= cfg_data[3:0];
          REG_CLEAR: reg_clear <= cfg_data[7:0];
          REG_JUMP:  reg_jump  <= cfg_data;
          default: begin
          end
        endcase
      end

      if (m_tvalid && m_tready && (state != ST_OUTPUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          sum_x   <= '0;
          sum_y   <= '0;
          best    <= COLD_TEMP;
          scan_k  <= '0;
          rd_pend <= 1'b0;
          rd_last <= 1'b0;
          if (s_tvalid) begin
            cur  <= sample_t'(s_tdata[SAMPLE_W-1:0]);
            pass <= !s_tuser && !replay;
            if (s_tuser) begin
              missed <= '0;
              state  <= (count != '0) ? ST_RD_LAST : ST_APPEND;
            end else begin
              missed <= missed_inc;
              if (replay) begin
                state <= ST_SCAN;
              end else begin
                if (missed_inc > reg_clear) begin
                  oldest <= '0;
                  count  <= '0;
                end
                state <= ST_OUTPUT;
              end
            end
          end
        end
        ST_RD_LAST: begin
          state <= ST_SQUARE;
        end
        ST_SQUARE: begin
          dx_sq <= 16'(dx) * 16'(dx);
          dy_sq <= 16'(dy) * 16'(dy);
          state <= ST_JUMP;
        end
        ST_JUMP: begin
          if (18'(dx_sq) + 18'(dy_sq) > jump_sq) begin
            oldest <= '0;
            count  <= '0;
          end
          state <= ST_APPEND;
        end
        ST_APPEND: begin
          if (window_full) begin
            oldest <= (oldest == SLOT_W'(WINDOW_LEN - 1)) ? '0 : oldest + SLOT_W'(1);
          end else begin
            count <= count + CNT_W'(1);
          end
          state <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_k < count) begin
            scan_k  <= scan_k + CNT_W'(1);
            rd_pend <= 1'b1;
            rd_last <= (scan_k == count - CNT_W'(1));
          end else begin
            rd_pend <= 1'b0;
          end
          if (rd_pend) begin
            sum_x <= sum_x + SUM_W'(rd_data.x);
            sum_y <= sum_y + SUM_W'(rd_data.y);
            if (rd_data.temp > best) begin
              best <= rd_data.temp;
            end
            if ((rd_data.temp > best) || (rd_last && (best == COLD_TEMP))) begin
              pick_red   <= rd_data.red;
              pick_green <= rd_data.green;
              pick_blue  <= rd_data.blue;
            end
            div_start <= rd_last;
            if (rd_last) begin
              state <= ST_DIVIDE;
            end
          end
        end
        ST_DIVIDE: begin
          div_start <= 1'b0;
          if (div_done) begin
            state <= ST_OUTPUT;
          end
        end
        ST_OUTPUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tuser  <= !pass;
            m_tdata  <= pass ? TDATA_W'(cur) : TDATA_W'(result);
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW_LEN))
    else $error("Window fill exceeds the window length.");

  assert property (@(posedge clk) disable iff (rst)
    (oldest != '0) |-> window_full)
    else $error("Window start moved while the window is not full.");

  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_OUTPUT))
    else $error("Result raised outside the output state.");

  assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIVIDE))
    else $error("Divider finished while no division was pending.");

endmodule

`default_nettype wire

/* src/hss_window_mem.sv */
// ----------------------------------------------------------------------------
// Hot-spot smoother sample memory
// Single-port-write, single-port-read synchronous memory with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_window_mem #(
  parameter int DEPTH  = 8,
  parameter int ADDR_W = 3,
  parameter int DATA_W = 55
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [ADDR_W-1:0] wr_addr,
  input  wire logic [DATA_W-1:0] wr_data,
  input  wire logic              rd_en,
  input  wire logic [ADDR_W-1:0] rd_addr,
  output logic      [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* src/hss_mean_div.sv */
// ----------------------------------------------------------------------------
// Hot-spot smoother mean divider
// Restoring division of 2*sum+n by 2*n for both coordinates, one quotient
// bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hss_mean_div
  import hss_pkg::*;
#(
  parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
  input  wire logic                                     clk,
  input  wire logic                                     rst,
  input  wire logic                                     start,
  input  wire logic [COORD_W+$clog2(WINDOW_LEN+1)-1:0]  sum_x,
  input  wire logic [COORD_W+$clog2(WINDOW_LEN+1)-1:0]  sum_y,
  input  wire logic [$clog2(WINDOW_LEN+1)-1:0]          count,
  output logic                                          done,
  output logic [COORD_W-1:0]                            mean_x,
  output logic [COORD_W-1:0]                            mean_y
);

  localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = COORD_W + CNT_W;
  localparam int DVD_W  = SUM_W + 1;
  localparam int DSH_W  = CNT_W + COORD_W;
  localparam int CMP_W  = (DVD_W > DSH_W) ? DVD_W : DSH_W;
  localparam int STEP_W = $clog2(COORD_W);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(COORD_W - 1);

  logic [CMP_W-1:0]  rem_x;
  logic [CMP_W-1:0]  rem_y;
  logic [CMP_W-1:0]  dsh;
  logic [STEP_W-1:0] step;
  logic              run;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= !start && run && (step == STEP_LAST);
      if (start) begin
        rem_x <= CMP_W'({sum_x, 1'b0}) + CMP_W'(count);
        rem_y <= CMP_W'({sum_y, 1'b0}) + CMP_W'(count);
        dsh   <= CMP_W'({count, 1'b0}) << (COORD_W - 1);
        step  <= '0;
        run   <= 1'b1;
      end else if (run) begin
        if (rem_x >= dsh) begin
          rem_x  <= rem_x - dsh;
          mean_x <= {mean_x[COORD_W-2:0], 1'b1};
        end else begin
          mean_x <= {mean_x[COORD_W-2:0], 1'b0};
        end
        if (rem_y >= dsh) begin
          rem_y  <= rem_y - dsh;
          mean_y <= {mean_y[COORD_W-2:0], 1'b1};
        end else begin
          mean_y <= {mean_y[COORD_W-2:0], 1'b0};
        end
        dsh  <= dsh >> 1;
        step <= step + STEP_W'(1);
        if (step == STEP_LAST) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

`default_nettype wire
